FILE: rtl/em4100fdc_pkg.sv
package em4100fdc_pkg;

  localparam int unsigned ROW_W       = 5;
  localparam int unsigned CODE_ROWS   = 8;
  localparam int unsigned PARITY_ROWS = 6;
  localparam int unsigned TRIES       = 3;
  localparam int unsigned WIN_W       = ROW_W * CODE_ROWS;

  localparam logic [15:0] HOLD_RESET    = 16'd1000;
  localparam logic [31:0] CODE_ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        decoded;
    logic [31:0] code;
  } dec_result_t;

  // cut 5-bit rows off the window top: data nibble, even parity on rows 0-5
  function automatic dec_result_t check_rows(logic [WIN_W-1:0] x);
    dec_result_t res;
    logic [ROW_W-1:0] row;
    res.decoded = 1'b1;
    res.code    = '0;
    for (int r = 0; r < CODE_ROWS; r++) begin
      row = x[WIN_W-1-ROW_W*r -: ROW_W];
      res.code = {res.code[27:0], row[4:1]};
      if (r < PARITY_ROWS && (^row)) begin
        res.decoded = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/em4100fdc_in_if.sv
interface em4100fdc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] raw_frame;

  modport source (output valid, output command, output raw_frame, input ready);
  modport sink   (input valid, input command, input raw_frame, output ready);
endinterface

FILE: rtl/em4100fdc_out_if.sv
interface em4100fdc_out_if;
  logic        valid;
  logic        ready;
  logic        decoded;
  logic        report;
  logic [31:0] card_code;

  modport source (output valid, output decoded, output report, output card_code,
                  input ready);
  modport sink   (input valid, input decoded, input report, input card_code,
                  output ready);
endinterface

FILE: rtl/em4100_frame_decode_confirm_top.sv
// card frame decoder with repeat confirmation. each beat on frame is either a
// 64-bit raw frame (command 0) or a millisecond tick (command 1) and gives
// exactly one beat on result. a new beat is taken every cycle unless result
// is stalled; a beat passes the input register, then the result register. a
// frame reloads the hold counter from hold_ticks (written through cfg_we/
// cfg_data, reset 1000); a tick counts it down and clears the stored code
// history when it reaches zero. a code other than zero or all ones decoded
// twice in a row is flagged with report once per 256-step turn of the repeat
// counter. write hold_ticks only while idle.
module em4100_frame_decode_confirm_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  em4100fdc_in_if.sink           frame,
  em4100fdc_out_if.source        result
);

  logic        in_valid;
  logic        in_command;
  logic [63:0] in_raw;

  logic        out_valid;
  logic        out_decoded;
  logic        out_report;
  logic [31:0] out_code;

  logic [15:0] hold_ticks;
  logic [31:0] last_code;
  logic [7:0]  repeat_count;
  logic [15:0] hold_counter;

  logic [31:0] last_code_next;
  logic [7:0]  repeat_count_next;
  logic [15:0] hold_counter_next;
  logic        report_next;

  logic        advance;
  logic        take;

  em4100fdc_pkg::dec_result_t dec;

  em4100fdc_decode u_decode (
    .raw_frame (in_raw),
    .result    (dec)
  );

  assign advance     = !out_valid || result.ready;
  assign take        = in_valid && advance;
  assign frame.ready = !in_valid || advance;

  always_comb begin
    last_code_next    = last_code;
    repeat_count_next = repeat_count;
    hold_counter_next = hold_counter;
    report_next       = 1'b0;
    if (in_command) begin
      if (hold_counter != '0) begin
        hold_counter_next = hold_counter - 16'd1;
        if (hold_counter == 16'd1) begin
          last_code_next    = '0;
          repeat_count_next = '0;
        end
      end
    end else begin
      hold_counter_next = hold_ticks;
      if (dec.decoded) begin
        if (dec.code == last_code && dec.code != '0 &&
            dec.code != em4100fdc_pkg::CODE_ALL_ONES) begin
          repeat_count_next = repeat_count + 8'd1;
          // counter goes to one only from zero
          report_next       = (repeat_count == '0);
        end else begin
          last_code_next    = dec.code;
          repeat_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= em4100fdc_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      in_command <= frame.command;
      in_raw     <= frame.raw_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_code    <= '0;
      repeat_count <= '0;
      hold_counter <= em4100fdc_pkg::HOLD_RESET;
    end else if (take) begin
      last_code    <= last_code_next;
      repeat_count <= repeat_count_next;
      hold_counter <= hold_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_decoded <= !in_command && dec.decoded;
      out_report  <= !in_command && report_next;
      out_code    <= in_command ? '0 : dec.code;
    end
  end

  assign result.valid     = out_valid;
  assign result.decoded   = out_decoded;
  assign result.report    = out_report;
  assign result.card_code = out_code;

endmodule

FILE: rtl/em4100fdc_decode.sv
module em4100fdc_decode (
  input  logic [63:0]                raw_frame,
  output em4100fdc_pkg::dec_result_t result
);

  logic [3:0]                       lead;
  logic [63:0]                      aligned;
  logic [em4100fdc_pkg::WIN_W+1:0]  top_win;
  logic [em4100fdc_pkg::WIN_W+1:0]  shifted;
  em4100fdc_pkg::dec_result_t       try_res;
  logic                             top_nz;

  // leading zeros of the top word; highest set bit wins
  always_comb begin
    lead = 4'd15;
    for (int i = 0; i < 16; i++) begin
      if (raw_frame[48+i]) begin
        lead = 4'(15 - i);
      end
    end
  end

  assign top_nz  = |raw_frame[63:48];
  assign aligned = raw_frame << lead;
  assign top_win = aligned[63:64-(em4100fdc_pkg::WIN_W+2)];

  // later tries checked first so the least shifted passing try wins
  always_comb begin
    result  = '0;
    shifted = '0;
    try_res = '0;
    for (int k = em4100fdc_pkg::TRIES - 1; k >= 0; k--) begin
      shifted = top_win >> k;
      try_res = em4100fdc_pkg::check_rows(shifted[em4100fdc_pkg::WIN_W+1:2]);
      if (top_nz && (4'(k) <= lead) && try_res.decoded) begin
        result = try_res;
      end
    end
  end

endmodule

FILE: sim/em4100fdc_tb_pkg.sv
package em4100fdc_tb_pkg;

  // what one beat on the frame channel carries
  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } item_cmd_t;

endpackage

FILE: sim/em4100fdc_card_checker.sv
module em4100fdc_card_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_command,
  input  logic [63:0] in_raw,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_decoded,
  input  logic        out_report,
  input  logic [31:0] out_code,
  output int          errors,
  output int          outstanding
);
  import em4100fdc_pkg::*;
  import em4100fdc_tb_pkg::*;

  typedef struct packed {
    logic        decoded;
    logic        report;
    logic [31:0] card_code;
  } card_result_t;

  card_result_t expected_cards[$];
  int           err_total = 0;

  logic [15:0] hold_reload;
  logic [15:0] hold_left;
  logic [31:0] prev_code;
  logic [7:0]  repeat_cnt;

  // decodes one beat and updates the confirmation history
  function automatic card_result_t decode_and_confirm(input logic cmd, input logic [63:0] raw);
    card_result_t res;
    logic [63:0]  aligned;
    logic [31:0]  code;
    logic         ok;
    int           lead;
    res = '0;
    if (cmd == CMD_TICK) begin
      if (hold_left != 16'd0) begin
        hold_left = hold_left - 16'd1;
        if (hold_left == 16'd0) begin
          prev_code  = '0;
          repeat_cnt = '0;
        end
      end
    end else begin
      hold_left = hold_reload;
      if (raw[63:48] != 16'd0) begin
        lead = 0;
        while (!raw[63-lead]) lead++;
        // try the left-aligned frame, then up to two positions further right
        for (int k = 0; k < TRIES && k <= lead && !res.decoded; k++) begin
          aligned = raw << (lead - k);
          ok      = 1'b1;
          code    = '0;
          for (int r = 0; r < 8; r++) begin
            code = {code[27:0], aligned[63-5*r -: 4]};
            if (r < 6 && aligned[59-5*r] != ^aligned[63-5*r -: 4]) ok = 1'b0;
          end
          if (ok) begin
            res.decoded   = 1'b1;
            res.card_code = code;
            if (code == prev_code && code != '0 && code != CODE_ALL_ONES) begin
              repeat_cnt = repeat_cnt + 8'd1;
              if (repeat_cnt == 8'd1) res.report = 1'b1;
            end else begin
              prev_code  = code;
              repeat_cnt = '0;
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    card_result_t want;
    if (rst) begin
      hold_reload = HOLD_RESET;
      hold_left   = HOLD_RESET;
      prev_code   = '0;
      repeat_cnt  = '0;
      expected_cards.delete();
    end else begin
      if (cfg_we) hold_reload = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_cards.size() == 0) begin
          $display("%0t: result beat with nothing expected: decoded=%0d report=%0d code=%h",
                   $time, out_decoded, out_report, out_code);
          err_total++;
        end else begin
          want = expected_cards.pop_front();
          if (out_decoded !== want.decoded) begin
            $display("%0t: decoded mismatch: expected %0d, actual %0d",
                     $time, want.decoded, out_decoded);
            err_total++;
          end
          if (out_report !== want.report) begin
            $display("%0t: report mismatch: expected %0d, actual %0d",
                     $time, want.report, out_report);
            err_total++;
          end
          if (out_code !== want.card_code) begin
            $display("%0t: card_code mismatch: expected %h, actual %h",
                     $time, want.card_code, out_code);
            err_total++;
          end
        end
      end
      if (in_valid && in_ready) expected_cards.push_back(decode_and_confirm(in_command, in_raw));
    end
    errors      <= err_total;
    outstanding <= expected_cards.size();
  end

endmodule

FILE: sim/em4100_frame_decode_confirm_top_tb.sv
module em4100_frame_decode_confirm_top_tb;
  import em4100fdc_pkg::*;
  import em4100fdc_tb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;
  int          errors;
  int          outstanding;
  bit          idle_on;
  bit          hold_off_req;
  logic [31:0] code_pool[4];

  em4100fdc_in_if  frame_if();
  em4100fdc_out_if result_if();

  em4100_frame_decode_confirm_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .frame    (frame_if),
    .result   (result_if)
  );

  em4100fdc_card_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (frame_if.valid),
    .in_ready    (frame_if.ready),
    .in_command  (frame_if.command),
    .in_raw      (frame_if.raw_frame),
    .out_valid   (result_if.valid),
    .out_ready   (result_if.ready),
    .out_decoded (result_if.decoded),
    .out_report  (result_if.report),
    .out_code    (result_if.card_code),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("em4100_frame_decode_confirm_top_tb NOT OK");
    $finish;
  end

  // encodes code in rows, even parity on rows 0-5, random bits below, shifts right
  function automatic logic [63:0] make_frame(input logic [31:0] code, input int shift);
    logic [63:0] x;
    logic [3:0]  nib;
    x = {$urandom, $urandom};
    for (int r = 0; r < 8; r++) begin
      nib = code[31-4*r -: 4];
      x[63-5*r -: 5] = {nib, (r < 6) ? ^nib : x[59-5*r]};
    end
    return x >> shift;
  endfunction

  task automatic send_beat(input item_cmd_t cmd, input logic [63:0] raw);
    int gap;
    int pick;
    gap = 0;
    if (idle_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93)      gap = $urandom_range(10, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid     <= 1'b1;
    frame_if.command   <= cmd;
    frame_if.raw_frame <= raw;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  task automatic set_hold(input logic [15:0] ticks);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int          pick;
    logic [63:0] raw;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        code_pool[$urandom_range(0, 3)] = ($urandom_range(0, 7) == 0) ? CODE_ALL_ONES : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        raw = make_frame(code_pool[$urandom_range(0, 3)],
                         ($urandom_range(0, 9) == 0) ? $urandom_range(5, 13) : $urandom_range(0, 4));
        send_beat(CMD_FRAME, raw);
      end else if (pick < 62) begin
        send_beat(CMD_TICK, {$urandom, $urandom});
      end else if (pick < 70) begin
        // well-formed frame with one bit flipped
        raw = make_frame(code_pool[$urandom_range(0, 3)], $urandom_range(0, 4));
        raw ^= 64'd1 << $urandom_range(0, 63);
        send_beat(CMD_FRAME, raw);
      end else if (pick < 78) begin
        send_beat(CMD_FRAME, {$urandom, $urandom});
      end else if (pick < 83) begin
        raw = {$urandom, $urandom};
        raw[63:48] = '0;
        send_beat(CMD_FRAME, raw);
      end else if (pick < 88) begin
        raw = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1) raw[63] = 1'b1;
        else                           raw[63:62] = 2'b01;
        send_beat(CMD_FRAME, raw);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 6)) send_beat(CMD_TICK, {$urandom, $urandom});
      end else begin
        drain();
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int pick;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!idle_on) begin
        result_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          result_if.ready <= 1'b1;
        end else begin
          result_if.ready <= 1'b0;
          stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end
      end
    end
  end

  initial begin
    logic [63:0] raw;
    logic [31:0] wrap_code;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    frame_if.valid     <= 1'b0;
    frame_if.command   <= CMD_FRAME;
    frame_if.raw_frame <= '0;
    idle_on      = 1'b0;
    hold_off_req = 1'b0;
    for (int i = 0; i < 4; i++) code_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats, reset hold time
    send_beat(CMD_TICK, '0);
    send_beat(CMD_FRAME, 64'h0000_FFFF_FFFF_FFFF);
    send_beat(CMD_FRAME, '0);
    send_beat(CMD_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(CMD_FRAME, 64'h8000_0000_0000_0000);
    send_beat(CMD_FRAME, 64'h4000_0000_0000_0000);
    send_beat(CMD_FRAME, make_frame(32'h9A3C_5E17, 0));
    send_beat(CMD_FRAME, make_frame(32'h9A3C_5E17, 3));
    send_beat(CMD_FRAME, make_frame(32'h9A3C_5E17, 13));
    raw = make_frame(32'h9A3C_5E17, 0);
    raw[59] = ~raw[59];
    send_beat(CMD_FRAME, raw);
    send_beat(CMD_FRAME, make_frame(CODE_ALL_ONES, 0));
    send_beat(CMD_FRAME, make_frame(CODE_ALL_ONES, 2));
    // first one one and two places below the top of the code window
    send_beat(CMD_FRAME, make_frame(32'h4123_4567, 2));
    send_beat(CMD_FRAME, make_frame(32'h4123_4567, 0));
    send_beat(CMD_FRAME, make_frame(32'h2ABC_DEF0, 1));
    send_beat(CMD_FRAME, make_frame(32'h2ABC_DEF0, 5));
    send_beat(CMD_FRAME, make_frame(32'h1357_9BDF, 0));
    send_beat(CMD_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(CMD_FRAME, make_frame(32'hFEDC_BA98, 0));

    idle_on = 1'b1;
    run_random(110);

    // zero hold time: ticks never clear the history
    set_hold(16'd0);
    run_random(110);

    set_hold(16'd1);
    run_random(110);

    // long result hold-off while frames keep coming
    set_hold(16'd3);
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) send_beat(CMD_FRAME, make_frame(code_pool[$urandom_range(0, 3)], 0));
    drain();
    idle_on = 1'b1;
    run_random(110);

    // repeat counter wrap with one code sent many times
    set_hold(16'hFFFF);
    wrap_code = ($urandom | 32'h8000_0000) & ~32'h1;
    repeat (260) send_beat(CMD_FRAME, make_frame(wrap_code, $urandom_range(0, 4)));
    run_random(100);

    set_hold(16'($urandom_range(4, 40)));
    idle_on = 1'b0;
    run_random(110);
    idle_on = 1'b1;

    set_hold(16'd2);
    run_random(110);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("em4100_frame_decode_confirm_top_tb OK");
    else
      $display("em4100_frame_decode_confirm_top_tb NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/em4100fdc_pkg.sv
rtl/em4100fdc_in_if.sv
rtl/em4100fdc_out_if.sv
rtl/em4100fdc_decode.sv
rtl/em4100_frame_decode_confirm_top.sv
sim/em4100fdc_tb_pkg.sv
sim/em4100fdc_card_checker.sv
sim/em4100_frame_decode_confirm_top_tb.sv
